@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

    // pool geometry
    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;

    localparam int BMAP_WORDS = (MAX_PAGES + 31) / 32;
    localparam int WORD_AW    = (BMAP_WORDS > 1) ? $clog2(BMAP_WORDS) : 1;
    localparam int PAGE_IW    = $clog2(MAX_PAGES);

    // field widths
    localparam int KIND_W   = 2;
    localparam int COUNT_W  = 11;
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 23;
    localparam int STATUS_W = 2;

    localparam int PAGE_CNT_W = $clog2(MAX_PAGES + 1);
    localparam int CNT_W      = (PAGE_CNT_W > COUNT_W) ? PAGE_CNT_W : COUNT_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES = 1'b1;

    localparam logic [SIZE_W-1:0] POOL_BYTES_RESET = 23'd4194304;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BUMP  = 2'd2;

    // result codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_MEM   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] page_count;
        logic [ADDR_W-1:0]  free_address;
        logic [SIZE_W-1:0]  byte_size;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_CHK,
        S_SCAN,
        S_MARK_RD,
        S_MARK,
        S_FREE_CHK,
        S_FREE_UPD,
        S_BUMP,
        S_BUMP_ADDR,
        S_RESP
    } t_state;

    // n low bits set, n from 0 to 32
    function automatic logic [31:0] low_ones(input logic [5:0] n);
        logic [32:0] t;
        t = (33'd1 << n) - 33'd1;
        return t[31:0];
    endfunction

endpackage

@@ rtl/bitmap_page_allocator.sv @@
// Page allocator over a used-page bitmap held in a 32-bit-wide synchronous RAM, one bit per
// page, plus a bump pointer that takes bytes from the top of the pool. One request is in
// work at a time; the next is taken as soon as the previous result is in the output
// register. A page allocation loads the limit, checks the count, scans the bitmap word by
// word (at most ceil(limit/32) words, limit being the page count below the top offset),
// reads the run's first word, read-modify-writes each word the run covers and posts the
// result; a zero or oversized count skips scan and mark. A free checks the address, clears
// the page's bit if the address is good and the page in use, and posts the result; a bump
// allocation lowers the top offset and posts the new address, or posts a failure at once. No
// clearing pass follows reset: per-word valid flags make unwritten words read as free.
module bitmap_page_allocator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  bpa_pkg::t_req                          i_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output bpa_pkg::t_rsp                          o_out,
    input  logic                                   i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);

    localparam int CW = bpa_pkg::CNT_W;
    localparam int AW = bpa_pkg::WORD_AW;
    localparam int PW = bpa_pkg::PAGE_IW;

    bpa_pkg::t_state r_state, n_state;
    bpa_pkg::t_req   r_req;
    bpa_pkg::t_rsp   r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic [31:0]                  r_base;
    logic [bpa_pkg::SIZE_W-1:0]   r_top, n_top;

    // bitmap memory
    logic [31:0]                  mem [bpa_pkg::BMAP_WORDS];
    logic [bpa_pkg::BMAP_WORDS-1:0] r_wvld;
    logic [AW-1:0]                rd_addr;
    logic [31:0]                  r_rdata;
    logic                         r_rvld;
    logic [31:0]                  rword;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [31:0]                  wr_data;

    logic [CW-1:0]   r_limit, n_limit;
    logic [AW-1:0]   r_wi, n_wi;
    logic [CW-1:0]   r_run, n_run;
    logic [PW-1:0]   r_start, n_start;
    logic [PW-1:0]   r_end, n_end;
    logic [AW-1:0]   r_mw, n_mw;
    logic [AW-1:0]   r_ew, n_ew;
    logic            r_bad, n_bad;
    logic [PW-1:0]   r_page, n_page;
    logic [bpa_pkg::STATUS_W-1:0] r_status, n_status;
    logic [31:0]     r_addr, n_addr;

    // scan datapath
    logic [CW:0]     want_w;
    logic [CW:0]     run_w;
    logic [CW:0]     pbase;
    logic [CW:0]     rem;
    logic [31:0]     vmask;
    logic [31:0]     free;
    logic [31:0]     hit;
    logic            found;
    logic [4:0]      first_j;
    logic [4:0]      hz;
    logic            all_free;
    logic [CW:0]     first_p1;
    logic [PW-1:0]   hit_start;
    logic [PW-1:0]   hit_end;
    logic            last_word;
    logic [CW-1:0]   run_nxt;
    logic [PW-1:0]   start_nxt;
    logic [CW-1:0]   lim_calc;
    logic [23:0]     lim_w;

    // mark datapath
    logic [4:0]      mk_lo, mk_hi;
    logic [31:0]     mark_mask;

    // free datapath
    logic [32:0]     pool_end;
    logic [31:0]     offs;
    logic [31:0]     pg_wide;
    logic            free_bad;

    assign rword = r_rvld ? r_rdata : '0;

    assign o_in_stall  = (r_state != bpa_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- scan of one bitmap word ----------------
    assign want_w   = (CW+1)'(r_req.page_count);
    assign run_w    = (CW+1)'(r_run);
    assign pbase    = (CW+1)'(r_wi) << 5;
    assign rem      = (CW+1)'(r_limit) - pbase;
    assign vmask    = (rem >= (CW+1)'(32)) ? '1 : bpa_pkg::low_ones(rem[5:0]);
    assign free     = ~rword & vmask;
    assign all_free = &free;

    always_comb begin
        logic [5:0] jp1;
        logic       big, win, pfx, reach;
        hit = '0;
        for (int j = 0; j < 32; j++) begin
            jp1   = 6'(j + 1);
            big   = (want_w <= (CW+1)'(j + 1));
            win   = &(free | ~(bpa_pkg::low_ones(jp1) &
                               ~bpa_pkg::low_ones(jp1 - want_w[5:0])));
            pfx   = &(free | ~bpa_pkg::low_ones(jp1));
            reach = (run_w + (CW+1)'(j + 1)) >= want_w;
            hit[j] = big ? win : (pfx && reach);
        end
    end

    always_comb begin
        first_j = '0;
        for (int j = 31; j >= 0; j--) begin
            if (hit[j]) begin
                first_j = 5'(j);
            end
        end
        hz = '0;
        for (int j = 0; j < 32; j++) begin
            if (!free[j]) begin
                hz = 5'(j);
            end
        end
    end

    assign found    = |hit;
    assign first_p1 = (CW+1)'(first_j) + (CW+1)'(1);
    // a hit before the window fits in the word continues the run from earlier words
    assign hit_start = (first_p1 < want_w) ? r_start : PW'(pbase + first_p1 - want_w);
    assign hit_end   = PW'(pbase + (CW+1)'(first_j));
    assign last_word = (pbase + (CW+1)'(32)) >= (CW+1)'(r_limit);

    always_comb begin
        if (all_free) begin
            run_nxt   = CW'(run_w + (CW+1)'(32));
            start_nxt = (r_run == '0) ? PW'(pbase) : r_start;
        end else begin
            run_nxt   = CW'(5'd31 - hz);
            start_nxt = PW'(pbase + (CW+1)'(hz) + (CW+1)'(1));
        end
    end

    assign lim_w    = 24'(r_top) >> bpa_pkg::PAGE_SHIFT;
    assign lim_calc = (lim_w > 24'(bpa_pkg::MAX_PAGES)) ? CW'(bpa_pkg::MAX_PAGES) : CW'(lim_w);

    // ---------------- mark mask ----------------
    assign mk_lo = (r_mw == AW'(r_start >> 5)) ? r_start[4:0] : 5'd0;
    assign mk_hi = (r_mw == r_ew) ? r_end[4:0] : 5'd31;
    assign mark_mask = bpa_pkg::low_ones(6'(mk_hi) + 6'd1) & ~bpa_pkg::low_ones(6'(mk_lo));

    // ---------------- free checks ----------------
    assign pool_end = {1'b0, r_base} + 33'(r_top);
    assign offs     = r_req.free_address - r_base;
    assign pg_wide  = offs >> bpa_pkg::PAGE_SHIFT;
    assign free_bad = (r_req.free_address < r_base)
                   || ({1'b0, r_req.free_address} >= pool_end)
                   || (r_req.free_address[bpa_pkg::PAGE_SHIFT-1:0] != '0)
                   || (pg_wide >= 32'(bpa_pkg::MAX_PAGES));

    // ---------------- control ----------------
    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_wi        = r_wi;
        n_run       = r_run;
        n_start     = r_start;
        n_end       = r_end;
        n_mw        = r_mw;
        n_ew        = r_ew;
        n_bad       = r_bad;
        n_page      = r_page;
        n_status    = r_status;
        n_addr      = r_addr;
        n_top       = r_top;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        case (r_state)
            bpa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.kind)
                        bpa_pkg::KIND_ALLOC: n_state = bpa_pkg::S_ALLOC;
                        bpa_pkg::KIND_FREE:  n_state = bpa_pkg::S_FREE_CHK;
                        bpa_pkg::KIND_BUMP:  n_state = bpa_pkg::S_BUMP;
                        default: begin
                            n_status = bpa_pkg::ST_OK;
                            n_addr   = '0;
                            n_state  = bpa_pkg::S_RESP;
                        end
                    endcase
                end
            end
            bpa_pkg::S_ALLOC: begin
                n_limit = lim_calc;
                n_state = bpa_pkg::S_ALLOC_CHK;
            end
            bpa_pkg::S_ALLOC_CHK: begin
                if (want_w == '0) begin
                    n_status = bpa_pkg::ST_OK;
                    n_addr   = r_base;
                    n_state  = bpa_pkg::S_RESP;
                end else if (want_w > (CW+1)'(r_limit)) begin
                    n_status = bpa_pkg::ST_NO_PAGES;
                    n_addr   = '0;
                    n_state  = bpa_pkg::S_RESP;
                end else begin
                    rd_addr = '0;
                    n_wi    = '0;
                    n_run   = '0;
                    n_start = '0;
                    n_state = bpa_pkg::S_SCAN;
                end
            end
            bpa_pkg::S_SCAN: begin
                // next word is fetched ahead while this one is examined
                rd_addr = r_wi + AW'(1);
                if (found) begin
                    n_start = hit_start;
                    n_end   = hit_end;
                    n_state = bpa_pkg::S_MARK_RD;
                end else if (last_word) begin
                    n_status = bpa_pkg::ST_NO_PAGES;
                    n_addr   = '0;
                    n_state  = bpa_pkg::S_RESP;
                end else begin
                    n_wi    = r_wi + AW'(1);
                    n_run   = run_nxt;
                    n_start = start_nxt;
                end
            end
            bpa_pkg::S_MARK_RD: begin
                rd_addr = AW'(r_start >> 5);
                n_mw    = AW'(r_start >> 5);
                n_ew    = AW'(r_end >> 5);
                n_state = bpa_pkg::S_MARK;
            end
            bpa_pkg::S_MARK: begin
                wr_en   = 1'b1;
                wr_addr = r_mw;
                wr_data = rword | mark_mask;
                if (r_mw == r_ew) begin
                    n_status = bpa_pkg::ST_OK;
                    n_addr   = r_base + (32'(r_start) << bpa_pkg::PAGE_SHIFT);
                    n_state  = bpa_pkg::S_RESP;
                end else begin
                    rd_addr = r_mw + AW'(1);
                    n_mw    = r_mw + AW'(1);
                end
            end
            bpa_pkg::S_FREE_CHK: begin
                n_bad   = free_bad;
                n_page  = PW'(pg_wide);
                rd_addr = AW'(pg_wide >> 5);
                n_state = bpa_pkg::S_FREE_UPD;
            end
            bpa_pkg::S_FREE_UPD: begin
                n_addr = '0;
                if (!r_bad && rword[r_page[4:0]]) begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(r_page >> 5);
                    wr_data  = rword & ~(32'd1 << r_page[4:0]);
                    n_status = bpa_pkg::ST_OK;
                end else begin
                    n_status = bpa_pkg::ST_BAD_FREE;
                end
                n_state = bpa_pkg::S_RESP;
            end
            bpa_pkg::S_BUMP: begin
                if (r_req.byte_size > r_top) begin
                    n_status = bpa_pkg::ST_NO_MEM;
                    n_addr   = '0;
                    n_state  = bpa_pkg::S_RESP;
                end else begin
                    n_top   = r_top - r_req.byte_size;
                    n_state = bpa_pkg::S_BUMP_ADDR;
                end
            end
            bpa_pkg::S_BUMP_ADDR: begin
                n_status = bpa_pkg::ST_OK;
                n_addr   = r_base + 32'(r_top);
                n_state  = bpa_pkg::S_RESP;
            end
            bpa_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status         = r_status;
                    n_out.result_address = r_addr;
                    n_out_valid          = 1'b1;
                    n_state              = bpa_pkg::S_IDLE;
                end
            end
            default: n_state = bpa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration and top offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_top  <= bpa_pkg::POOL_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bpa_pkg::REG_POOL_BASE:  r_base <= i_cfg_wdata;
                bpa_pkg::REG_POOL_BYTES: r_top  <= i_cfg_wdata[bpa_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end else begin
            r_top <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req <= i_in;
        end
        r_out    <= n_out;
        r_limit  <= n_limit;
        r_wi     <= n_wi;
        r_run    <= n_run;
        r_start  <= n_start;
        r_end    <= n_end;
        r_mw     <= n_mw;
        r_ew     <= n_ew;
        r_bad    <= n_bad;
        r_page   <= n_page;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    // bitmap ram: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // words never written read as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_wvld[wr_addr] <= 1'b1;
            end
            r_rvld <= r_wvld[rd_addr];
        end
    end

endmodule

@@ rtl/bpa_checker.sv @@
module bpa_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   o_in_stall,
    input  bpa_pkg::t_req                          i_in,
    input  logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    input  bpa_pkg::t_rsp                          o_out,
    input  logic                                   i_cfg_we,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken while busy");

    // a new result only appears after the block was busy with a request
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result with no request in work");

    // failures carry a zero address
    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != bpa_pkg::ST_OK)) |-> (o_out.result_address == '0))
        else $error("failed result with nonzero address");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
